>>> hw/rtl/mpd_pkg.sv
// shared codes and types of the mqtt packet deframer
// no dependencies

package mpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int ROLE_W  = 3;
    localparam int PHASE_W = 2;
    localparam int TLEN_W  = 16;

    localparam logic [KIND_W-1:0] KIND_CONNACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUBLISH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUBACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PINGRESP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd4;

    localparam logic [ROLE_W-1:0] ROLE_BODY    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_TLEN_HI = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_TLEN_LO = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_EMPTY   = 3'd5;

    localparam logic [PHASE_W-1:0] PH_TYPE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LENGTH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BODY   = 2'd2;

    localparam logic [BYTE_W-1:0] TYPE_CONNACK   = 8'h20;
    localparam logic [BYTE_W-1:0] TYPE_PUBLISH_0 = 8'h30;
    localparam logic [BYTE_W-1:0] TYPE_PUBLISH_1 = 8'h31;
    localparam logic [BYTE_W-1:0] TYPE_PUBLISH_2 = 8'h32;
    localparam logic [BYTE_W-1:0] TYPE_PUBLISH_4 = 8'h34;
    localparam logic [BYTE_W-1:0] TYPE_SUBACK    = 8'h90;
    localparam logic [BYTE_W-1:0] TYPE_PINGRESP  = 8'hD0;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] pkt_type;
        logic [ROLE_W-1:0] byte_role;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] body_index;
        logic              last;
    } mpd_result_t;

endpackage

>>> hw/rtl/mpd_if.sv
// valid/ready channels of the mqtt packet deframer
// stand-alone, widths follow the byte and code widths of mpd_pkg

interface mpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] pkt_type;
    logic [2:0] byte_role;
    logic [7:0] data_byte;
    logic [7:0] body_index;
    logic       last;

    modport source (output valid, output pkt_type, output byte_role, output data_byte,
                    output body_index, output last, input ready);
    modport sink   (input valid, input pkt_type, input byte_role, input data_byte,
                    input body_index, input last, output ready);
endinterface

>>> hw/rtl/mqtt_packet_deframer.sv
// top level of the mqtt packet deframer: parser plus output register
// depends on mpd_pkg, mpd_if (mpd_in_if, mpd_out_if) and mpd_parser
//
// channel  dir  payload                                           transfer
// din      in   rx_byte                                           valid & ready
// dout     out  pkt_type, byte_role, data_byte, body_index, last  valid & ready
//
// one byte per cycle while ready; result is on dout the cycle after the byte
// rst_n clears the framing state to expecting a type byte and empties dout
// din.ready drops only while a held result on dout is not taken
// type and nonzero length bytes and bytes of unknown packets give no result

module mqtt_packet_deframer
    import mpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mpd_in_if.sink           din,
    mpd_out_if.source        dout
);

    mpd_result_t        res;
    logic               accept;
    logic               valid_reg, valid_next;
    logic [KIND_W-1:0]  type_reg;
    logic [ROLE_W-1:0]  role_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [BYTE_W-1:0]  index_reg;
    logic               last_reg;

    assign din.ready = !valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    mpd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (din.rx_byte),
        .res     (res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = res.hit;
        end
        else if (dout.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.hit)
        begin
            type_reg  <= res.pkt_type;
            role_reg  <= res.byte_role;
            data_reg  <= res.data_byte;
            index_reg <= res.body_index;
            last_reg  <= res.last;
        end
    end

    assign dout.valid      = valid_reg;
    assign dout.pkt_type   = type_reg;
    assign dout.byte_role  = role_reg;
    assign dout.data_byte  = data_reg;
    assign dout.body_index = index_reg;
    assign dout.last       = last_reg;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dout.ready |-> !din.ready)
        else $error("input taken while result held");
    a_known_type: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> type_reg != KIND_UNKNOWN)
        else $error("result for unknown packet type");
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && role_reg == ROLE_EMPTY |-> last_reg && data_reg == '0 && index_reg == '0)
        else $error("malformed empty packet marker");
    a_tlen_hi_first: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && role_reg == ROLE_TLEN_HI |-> index_reg == '0)
        else $error("topic length high byte not at body start");
`endif

endmodule

>>> hw/rtl/mpd_classify.sv
// packet type classifier: maps a fixed header byte to a packet kind
// depends on mpd_pkg

module mpd_classify
    import mpd_pkg::*;
(
    input  logic [BYTE_W-1:0] type_byte,
    output logic [KIND_W-1:0] kind
);

    always_comb
    begin
        case (type_byte)
            TYPE_CONNACK:   kind = KIND_CONNACK;
            TYPE_PUBLISH_0,
            TYPE_PUBLISH_1,
            TYPE_PUBLISH_2,
            TYPE_PUBLISH_4: kind = KIND_PUBLISH;
            TYPE_SUBACK:    kind = KIND_SUBACK;
            TYPE_PINGRESP:  kind = KIND_PINGRESP;
            default:        kind = KIND_UNKNOWN;
        endcase
    end

endmodule

>>> hw/rtl/mpd_parser.sv
// framing state and byte role logic, one byte per transfer
// depends on mpd_pkg and mpd_classify

module mpd_parser
    import mpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output mpd_result_t       res
);

    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [KIND_W-1:0]  kind_reg,      kind_next;
    logic [BYTE_W-1:0]  remaining_reg, remaining_next;
    logic [BYTE_W-1:0]  position_reg,  position_next;
    logic [TLEN_W-1:0]  tlen_reg,      tlen_next;
    logic [KIND_W-1:0]  byte_kind;
    logic [TLEN_W-1:0]  topic_offset;
    logic               fin;

    mpd_classify u_classify (
        .type_byte (rx_byte),
        .kind      (byte_kind)
    );

    assign fin          = (remaining_reg <= 8'd1);
    assign topic_offset = {{(TLEN_W-BYTE_W){1'b0}}, position_reg} - TLEN_W'(2);

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        tlen_next      = tlen_reg;
        res            = '0;
        res.pkt_type   = kind_reg;
        case (phase_reg)
            PH_LENGTH:
            begin
                if (rx_byte == '0)
                begin
                    phase_next    = PH_TYPE;
                    res.hit       = (kind_reg != KIND_UNKNOWN);
                    res.byte_role = ROLE_EMPTY;
                    res.last      = 1'b1;
                end
                else
                begin
                    remaining_next = rx_byte;
                    position_next  = '0;
                    tlen_next      = '0;
                    phase_next     = PH_BODY;
                end
            end
            PH_BODY:
            begin
                res.hit        = (kind_reg != KIND_UNKNOWN);
                res.byte_role  = ROLE_BODY;
                res.data_byte  = rx_byte;
                res.body_index = position_reg;
                res.last       = fin;
                if (kind_reg == KIND_PUBLISH)
                begin
                    if (position_reg == 8'd0)
                    begin
                        res.byte_role = ROLE_TLEN_HI;
                        tlen_next     = {rx_byte, {BYTE_W{1'b0}}};
                    end
                    else if (position_reg == 8'd1)
                    begin
                        res.byte_role = ROLE_TLEN_LO;
                        tlen_next     = tlen_reg | {{(TLEN_W-BYTE_W){1'b0}}, rx_byte};
                    end
                    else if (topic_offset < tlen_reg)
                    begin
                        res.byte_role = ROLE_TOPIC;
                    end
                    else
                    begin
                        res.byte_role = ROLE_PAYLOAD;
                    end
                end
                position_next  = position_reg + 8'd1;
                remaining_next = remaining_reg - 8'd1;
                if (fin)
                begin
                    remaining_next = '0;
                    phase_next     = PH_TYPE;
                end
            end
            default:
            begin
                kind_next  = byte_kind;
                phase_next = PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            kind_reg      <= '0;
            remaining_reg <= '0;
            position_reg  <= '0;
            tlen_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            tlen_reg      <= tlen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("parser phase left its legal codes");
    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> remaining_reg != '0)
        else $error("body phase with no bytes remaining");
    a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.last |=> phase_reg == PH_TYPE)
        else $error("last transfer did not return to type phase");
`endif

endmodule

>>> tb/mqtt_packet_deframer_test.sv
`timescale 1ns / 100ps
// self-checking bench of the mqtt packet deframer: a byte stream in, results out
// depends on mpd_pkg, mpd_if (mpd_in_if, mpd_out_if) and the mqtt_packet_deframer top

module mqtt_packet_deframer_test
    import mpd_pkg::*;
();

    typedef struct packed {
        logic [KIND_W-1:0] pkt_type;
        logic [ROLE_W-1:0] byte_role;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] body_index;
        logic              last;
    } frag_t;

    typedef struct packed {
        logic              fixed;
        logic [BYTE_W-1:0] rx_byte;
        frag_t             frag;
    } stim_row_t;

    localparam frag_t NO_FRAG     = '0;
    localparam int    IDLE_LIMIT  = 2000;
    localparam int    HOLD_LEN    = 80;
    localparam int    PHASE_BYTES = 574;
    localparam int    DIR_N       = 28;

    // directed stream; rows marked fixed carry the result read off by hand
    stim_row_t dir_tab [DIR_N] = '{
        // connack and suback, both empty
        {1'b0, TYPE_CONNACK, NO_FRAG},
        {1'b1, 8'h00, KIND_CONNACK, ROLE_EMPTY, 8'h00, 8'h00, 1'b1},
        {1'b0, TYPE_SUBACK, NO_FRAG},
        {1'b1, 8'h00, KIND_SUBACK, ROLE_EMPTY, 8'h00, 8'h00, 1'b1},
        // pingresp with a single body byte
        {1'b0, TYPE_PINGRESP, NO_FRAG},
        {1'b0, 8'h01, NO_FRAG},
        {1'b1, 8'hFF, KIND_PINGRESP, ROLE_BODY, 8'hFF, 8'h00, 1'b1},
        // publish cut short after the high topic length byte
        {1'b0, TYPE_PUBLISH_1, NO_FRAG},
        {1'b0, 8'h01, NO_FRAG},
        {1'b1, 8'h00, KIND_PUBLISH, ROLE_TLEN_HI, 8'h00, 8'h00, 1'b1},
        // publish with one topic byte and a payload
        {1'b0, TYPE_PUBLISH_0, NO_FRAG},
        {1'b0, 8'h04, NO_FRAG},
        {1'b0, 8'h00, NO_FRAG},
        {1'b0, 8'h01, NO_FRAG},
        {1'b0, 8'h41, NO_FRAG},
        {1'b0, 8'h42, NO_FRAG},
        // topic length past the end of the body
        {1'b0, TYPE_PUBLISH_2, NO_FRAG},
        {1'b0, 8'h03, NO_FRAG},
        {1'b0, 8'hFF, NO_FRAG},
        {1'b0, 8'hFF, NO_FRAG},
        {1'b0, 8'h7E, NO_FRAG},
        // unknown types, one empty and one skipped by its length
        {1'b0, 8'hFF, NO_FRAG},
        {1'b0, 8'h00, NO_FRAG},
        {1'b0, 8'h7F, NO_FRAG},
        {1'b0, 8'h01, NO_FRAG},
        {1'b0, 8'h55, NO_FRAG},
        // empty publish
        {1'b0, TYPE_PUBLISH_4, NO_FRAG},
        {1'b1, 8'h00, KIND_PUBLISH, ROLE_EMPTY, 8'h00, 8'h00, 1'b1}
    };

    logic clk;
    logic rst_n;

    mpd_in_if  din_if ();
    mpd_out_if dout_if ();

    mqtt_packet_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    logic [PHASE_W-1:0] fr_phase;
    logic [KIND_W-1:0]  fr_kind;
    logic [BYTE_W-1:0]  fr_left;
    logic [BYTE_W-1:0]  fr_pos;
    logic [TLEN_W-1:0]  fr_tlen;

    frag_t frag_q [$];
    int    errors;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_req;
    int    idle_cycles;
    logic  fixed_valid;
    frag_t fixed_frag;

    function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] b);
        case (b)
            TYPE_CONNACK:   return KIND_CONNACK;
            TYPE_PUBLISH_0,
            TYPE_PUBLISH_1,
            TYPE_PUBLISH_2,
            TYPE_PUBLISH_4: return KIND_PUBLISH;
            TYPE_SUBACK:    return KIND_SUBACK;
            TYPE_PINGRESP:  return KIND_PINGRESP;
            default:        return KIND_UNKNOWN;
        endcase
    endfunction

    function void deframe_step(input logic [BYTE_W-1:0] b, output logic hit, output frag_t r);
        logic fin;
        hit = 1'b0;
        r   = NO_FRAG;
        case (fr_phase)
            PH_LENGTH:
            begin
                if (b == 8'd0)
                begin
                    fr_phase = PH_TYPE;
                    if (fr_kind != KIND_UNKNOWN)
                    begin
                        hit         = 1'b1;
                        r.pkt_type  = fr_kind;
                        r.byte_role = ROLE_EMPTY;
                        r.last      = 1'b1;
                    end
                end
                else
                begin
                    fr_left  = b;
                    fr_pos   = '0;
                    fr_tlen  = '0;
                    fr_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                fin         = (fr_left <= 8'd1);
                r.byte_role = ROLE_BODY;
                if (fr_kind == KIND_PUBLISH)
                begin
                    if (fr_pos == 8'd0)
                    begin
                        r.byte_role = ROLE_TLEN_HI;
                        fr_tlen     = {b, 8'd0};
                    end
                    else if (fr_pos == 8'd1)
                    begin
                        r.byte_role  = ROLE_TLEN_LO;
                        fr_tlen[7:0] = b;
                    end
                    else if (int'(fr_pos) - 2 < int'(fr_tlen))
                        r.byte_role = ROLE_TOPIC;
                    else
                        r.byte_role = ROLE_PAYLOAD;
                end
                hit          = (fr_kind != KIND_UNKNOWN);
                r.pkt_type   = fr_kind;
                r.data_byte  = b;
                r.body_index = fr_pos;
                r.last       = fin;
                fr_pos       = fr_pos + 8'd1;
                fr_left      = fin ? 8'd0 : fr_left - 8'd1;
                if (fin)
                    fr_phase = PH_TYPE;
            end
            default:
            begin
                fr_kind  = kind_of(b);
                fr_phase = PH_LENGTH;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // checker, predictor and watchdog, all on the rising edge
    always @(posedge clk)
    begin
        frag_t want;
        frag_t pred;
        logic  hit;
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (frag_q.size() == 0)
                    report_mismatch("result with none pending", 1, 0);
                else
                begin
                    want = frag_q.pop_front();
                    if (dout_if.pkt_type !== want.pkt_type)
                        report_mismatch("pkt_type", dout_if.pkt_type, want.pkt_type);
                    if (dout_if.byte_role !== want.byte_role)
                        report_mismatch("byte_role", dout_if.byte_role, want.byte_role);
                    if (dout_if.data_byte !== want.data_byte)
                        report_mismatch("data_byte", dout_if.data_byte, want.data_byte);
                    if (dout_if.body_index !== want.body_index)
                        report_mismatch("body_index", dout_if.body_index, want.body_index);
                    if (dout_if.last !== want.last)
                        report_mismatch("last", dout_if.last, want.last);
                end
            end
            if (din_if.valid && din_if.ready)
            begin
                deframe_step(din_if.rx_byte, hit, pred);
                if (fixed_valid)
                begin
                    pred = fixed_frag;
                    hit  = 1'b1;
                end
                if (hit)
                    frag_q.push_back(pred);
            end
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("mqtt_packet_deframer test failed");
                $finish;
            end
        end
    end

    // receiver side, with a single long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold     = hold_req;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fixed, input frag_t f);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            din_if.valid <= 1'b0;
            @(negedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.rx_byte <= b;
        fixed_valid = fixed;
        fixed_frag  = f;
        do
            @(posedge clk);
        while (!din_if.ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (frag_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_packet(inout int counted);
        logic [BYTE_W-1:0] type_b;
        logic [TLEN_W-1:0] tlen;
        logic [BYTE_W-1:0] b;
        int                len;
        int                r;
        int                n;
        r = $urandom_range(99);
        // noise: a short run of raw bytes that knocks the framing off
        if (r < 5)
        begin
            n = $urandom_range(6, 1);
            repeat (n)
                send_byte(8'($urandom), 1'b0, NO_FRAG);
            counted += n;
            return;
        end
        r = $urandom_range(99);
        if (r < 40)
        begin
            case ($urandom_range(3))
                0:       type_b = TYPE_PUBLISH_0;
                1:       type_b = TYPE_PUBLISH_1;
                2:       type_b = TYPE_PUBLISH_2;
                default: type_b = TYPE_PUBLISH_4;
            endcase
        end
        else if (r < 55)
            type_b = TYPE_CONNACK;
        else if (r < 70)
            type_b = TYPE_SUBACK;
        else if (r < 85)
            type_b = TYPE_PINGRESP;
        else
        begin
            do
                type_b = 8'($urandom);
            while (kind_of(type_b) != KIND_UNKNOWN);
        end
        r = $urandom_range(99);
        if (r < 3)
            len = ($urandom_range(1) == 0) ? 255 : $urandom_range(255, 128);
        else if (r < 13)
            len = 0;
        else if (r < 68)
            len = $urandom_range(8, 1);
        else
            len = $urandom_range(40, 9);
        r = $urandom_range(99);
        if (len < 2 || r >= 85)
            tlen = 16'($urandom_range(16'hFFFF));
        else if (r < 70)
            tlen = 16'($urandom_range(len - 2));
        else
            tlen = 16'(len - 2 + $urandom_range(4));
        send_byte(type_b, 1'b0, NO_FRAG);
        send_byte(8'(len), 1'b0, NO_FRAG);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            if (kind_of(type_b) == KIND_PUBLISH && i == 0)
                b = tlen[15:8];
            else if (kind_of(type_b) == KIND_PUBLISH && i == 1)
                b = tlen[7:0];
            send_byte(b, 1'b0, NO_FRAG);
        end
        // type byte, length byte and body
        counted += len + 2;
    endtask

    initial
    begin
        int counted;
        rst_n          = 1'b0;
        din_if.valid   = 1'b0;
        din_if.rx_byte = '0;
        dout_if.ready  = 1'b0;
        fixed_valid    = 1'b0;
        fixed_frag     = NO_FRAG;
        send_idle_pct  = 38;
        recv_idle_pct  = 65;
        hold_req       = 0;
        errors         = 0;
        idle_cycles    = 0;
        fr_phase       = PH_TYPE;
        fr_kind        = KIND_CONNACK;
        fr_left        = '0;
        fr_pos         = '0;
        fr_tlen        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].rx_byte, dir_tab[i].fixed, dir_tab[i].frag);

        for (int p = 0; p < 3; p++)
        begin
            drain_results();
            send_idle_pct = (p == 0) ? 38 : (p == 1) ? 65 : 0;
            recv_idle_pct = (p == 0) ? 65 : (p == 1) ? 38 : 0;
            // back-pressure: receiver stalls while bytes keep coming
            if (p == 0)
                hold_req = HOLD_LEN;
            counted = 0;
            while (counted < PHASE_BYTES)
                random_packet(counted);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("mqtt_packet_deframer test passed");
        else
            $display("mqtt_packet_deframer test failed");
        $finish;
    end

endmodule
